>>> rtl/ssps_pkg.sv
// Shared types, constants and helper functions of the seek steering particle block.
package ssps_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int VEC_W      = 34;
  localparam int DIV_W      = (2 * FRAC_BITS + 1 > 33) ? 2 * FRAC_BITS + 1 : 33;
  localparam int CNT_W      = $clog2(DIV_W + 1);
  localparam int SQRT_STEPS = 32;
  localparam int LEN_STEPS  = FRAC_BITS + 2;
  localparam int MASS_STEPS = 2 * FRAC_BITS + 1;

  localparam logic [31:0] Q_ONE    = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] SEEK_LEN = 32'(64'd5 << (FRAC_BITS - 1));
  localparam logic [63:0] Q_ONE_SQ = 64'd1 << (2 * FRAC_BITS);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS  = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TICK_V, ST_TICK_P, ST_MAG, ST_NORM, ST_SQ_MUL, ST_SQ_ACC,
    ST_SQRT_GO, ST_SQRT_WAIT, ST_LEN_MUL, ST_LEN_GO, ST_LEN_WAIT, ST_STEER,
    ST_MASS_GO, ST_MASS_WAIT, ST_ACC, ST_DONE
  } seq_state_e;

  typedef enum logic [1:0] {PH_SEEK, PH_CHECK, PH_CLAMP} phase_e;

  typedef enum logic {ITU_DIV, ITU_SQRT} itu_mode_e;

  typedef struct packed {
    logic             start;
    itu_mode_e        mode;
    logic [CNT_W-1:0] steps;
    logic [63:0]      radicand;
    logic [31:0]      rem0;
    logic [DIV_W-1:0] dividend_lo;
    logic [31:0]      divisor;
  } itu_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [31:0]      root;
  } itu_rsp_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } cfg_wr_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_out_x;
    logic signed [31:0] pos_out_y;
    logic signed [31:0] pos_out_z;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

  function automatic logic [VEC_W-1:0] mag(input logic signed [VEC_W-1:0] v);
    return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
  endfunction

endpackage

>>> rtl/ssps_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
interface ssps_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/seek_steering_particle_step.sv
// Top level of the seek steering particle: channels, result register and checks.
//
// One particle in signed Q16.16. Each request on in_if carries op and a target:
// op 0 seeks towards the target (the steering force, limited to length 1.0 and
// divided by mass, is added to acceleration); op 1 advances one tick.
// Every request returns the position after the step on out_if.
// The start position, start velocity and mass are written on the cfg port
// (index 0..6) while the block is idle, a rule on the user that the block does
// not enforce; a start write loads the live state directly. A tick runs through
// ST_TICK_V and ST_TICK_P to ST_DONE. A seek, longer when the force is limited,
// is paced by the shared divide and square-root unit, which settles one bit a
// cycle (32 root steps, 18-step length divisions, 33-step mass divisions).
// One request is processed at a time: in_if.ready is high only while the
// sequencer is idle. The result sits in an output register; a new request is
// taken while it waits, but the next result holds in the sequencer until the
// receiver takes the previous one.
// Reset clears position, velocity and acceleration and sets mass to 1.0.
module seek_steering_particle_step import ssps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ssps_stream_if.sink          in_if,
  ssps_stream_if.source        out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  cfg_wr_t   cfg;
  seq_stat_t stat;
  out_item_t seq_pos;
  out_item_t out_data_q;
  logic      out_valid_q;
  logic      in_acc;
  logic      seq_ack;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  assign in_if.ready = stat.idle;
  assign in_acc      = in_if.valid && stat.idle;
  assign seq_ack     = stat.done && (!out_valid_q || out_if.ready);

  ssps_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .start_i (in_acc),
    .item_i  (in_if.data),
    .ack_i   (seq_ack),
    .stat_o  (stat),
    .pos_o   (seq_pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_ack) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_ack) out_data_q <= seq_pos;
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_data_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_if.ready)
    else $error("request taken while a previous one is still in work");

  a_tick_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_if.data.op) |-> ##3 stat.done)
    else $error("tick result not ready three cycles after the request");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(stat.done))
    else $error("result register loaded without a finished step");

endmodule

>>> rtl/ssps_itu.sv
// Shared iterative unit: restoring division and integer square root, one bit a cycle.
module ssps_itu import ssps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  itu_req_t req_i,
  output itu_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  itu_mode_e        mode_q, mode_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      dvs_q, dvs_d;
  logic [DIV_W-1:0] lo_q, lo_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [63:0]      x_q, x_d;
  logic [63:0]      r_q, r_d;
  logic [63:0]      bit_q, bit_d;

  logic [32:0] trial;
  logic        ge;
  logic [63:0] rb;

  assign trial = {rem_q, lo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rb    = r_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    mode_d = mode_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    x_d    = x_q;
    r_d    = r_q;
    bit_d  = bit_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem0;
      dvs_d  = req_i.divisor;
      lo_d   = req_i.dividend_lo;
      quo_d  = '0;
      x_d    = req_i.radicand;
      r_d    = '0;
      bit_d  = 64'd1 << 62;
    end else if (busy_q) begin
      unique case (mode_q)
        ITU_DIV: begin
          rem_d = ge ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
          lo_d  = lo_q << 1;
          quo_d = {quo_q[DIV_W-2:0], ge};
        end
        ITU_SQRT: begin
          // Each step settles one bit of the root.
          if (x_q >= rb) begin
            x_d = x_q - rb;
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
        default: ;
      endcase
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= ITU_DIV;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    x_q   <= x_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.root = r_q[31:0];

endmodule

>>> rtl/ssps_seq.sv
// Sequencer and particle state: seek and tick steps driven over the shared unit.
module ssps_seq import ssps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_wr_t   cfg_i,
  input  logic      start_i,
  input  in_item_t  item_i,
  input  logic      ack_i,
  output seq_stat_t stat_o,
  output out_item_t pos_o
);

  seq_state_e state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [1:0] idx_q, idx_d;

  logic signed [31:0]      pos_q [3];
  logic signed [31:0]      pos_d [3];
  logic signed [31:0]      vel_q [3];
  logic signed [31:0]      vel_d [3];
  logic signed [31:0]      acc_q [3];
  logic signed [31:0]      acc_d [3];
  logic [31:0]             mass_q, mass_d;
  logic signed [VEC_W-1:0] v_q [3];
  logic signed [VEC_W-1:0] v_d [3];
  logic [VEC_W-1:0]        a_q [3];
  logic [VEC_W-1:0]        a_d [3];
  logic [63:0]             sum_q, sum_d;
  logic [63:0]             prod_q, prod_d;
  logic [31:0]             len_q, len_d;
  logic signed [31:0]      s_q, s_d;

  itu_req_t itu_req;
  itu_rsp_t itu_rsp;

  logic [VEC_W-1:0] m01, m_max;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [VEC_W-1:0] mg;
  logic [VEC_W-1:0] qv;
  logic [DIV_W-1:0] q;
  logic             over, all_zero;
  logic [63:0]      sum_n;

  ssps_itu u_itu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (itu_req),
    .rsp_o  (itu_rsp)
  );

  assign m01   = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
  assign m_max = (m01 > a_q[2]) ? m01 : a_q[2];
  assign mul_a = a_q[idx_q][31:0];
  assign mul_b = (state_q == ST_LEN_MUL) ? ((phase_q == PH_SEEK) ? SEEK_LEN : Q_ONE) : mul_a;
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  assign mg    = mag(v_q[idx_q]);
  assign q     = itu_rsp.quot;
  assign qv    = VEC_W'(itu_rsp.quot);
  assign sum_n = sum_q + prod_q;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    pos_d   = pos_q;
    vel_d   = vel_q;
    acc_d   = acc_q;
    mass_d  = mass_q;
    v_d     = v_q;
    a_d     = a_q;
    sum_d   = sum_q;
    prod_d  = prod_q;
    len_d   = len_q;
    s_d     = s_q;
    over    = 1'b0;
    all_zero = 1'b1;

    itu_req.start       = 1'b0;
    itu_req.mode        = ITU_DIV;
    itu_req.steps       = CNT_W'(LEN_STEPS);
    itu_req.radicand    = sum_q;
    itu_req.rem0        = prod_q[FRAC_BITS+33:FRAC_BITS+2];
    itu_req.dividend_lo = DIV_W'(prod_q[FRAC_BITS+1:0]) << (DIV_W - LEN_STEPS);
    itu_req.divisor     = len_q;

    // A cfg write of a start value loads that component of the live state directly.
    if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_POS_X: pos_d[0] = $signed(cfg_i.data);
        CFG_POS_Y: pos_d[1] = $signed(cfg_i.data);
        CFG_POS_Z: pos_d[2] = $signed(cfg_i.data);
        CFG_VEL_X: vel_d[0] = $signed(cfg_i.data);
        CFG_VEL_Y: vel_d[1] = $signed(cfg_i.data);
        CFG_VEL_Z: vel_d[2] = $signed(cfg_i.data);
        CFG_MASS:  mass_d   = cfg_i.data;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (item_i.op) begin
            state_d = ST_TICK_V;
          end else begin
            v_d[0]  = VEC_W'(item_i.target_x) - VEC_W'(pos_q[0]);
            v_d[1]  = VEC_W'(item_i.target_y) - VEC_W'(pos_q[1]);
            v_d[2]  = VEC_W'(item_i.target_z) - VEC_W'(pos_q[2]);
            phase_d = PH_SEEK;
            state_d = ST_MAG;
          end
        end
      end
      ST_TICK_V: begin
        for (int i = 0; i < 3; i++) begin
          vel_d[i] = sat32(35'(vel_q[i]) + 35'(acc_q[i]));
        end
        state_d = ST_TICK_P;
      end
      ST_TICK_P: begin
        for (int i = 0; i < 3; i++) begin
          pos_d[i] = sat32(35'(pos_q[i]) + 35'(vel_q[i]));
          acc_d[i] = '0;
        end
        state_d = ST_DONE;
      end
      ST_MAG: begin
        for (int i = 0; i < 3; i++) begin
          a_d[i] = mag(v_q[i]);
          if (a_d[i][VEC_W-1:31] != '0) over = 1'b1;
          if (a_d[i] != '0) all_zero = 1'b0;
        end
        idx_d = '0;
        sum_d = '0;
        if (phase_q == PH_CHECK) begin
          if (over) begin
            phase_d = PH_CLAMP;
            state_d = ST_NORM;
          end else begin
            state_d = ST_SQ_MUL;
          end
        end else if (all_zero) begin
          state_d = ST_STEER;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        // Bring the largest magnitude into [2^30, 2^31), coarse steps first.
        if (m_max[VEC_W-1:31] != '0) begin
          for (int i = 0; i < 3; i++) a_d[i] = a_q[i] >> 1;
        end else if (m_max[VEC_W-1:22] == '0) begin
          for (int i = 0; i < 3; i++) a_d[i] = a_q[i] << 8;
        end else if (!m_max[30]) begin
          for (int i = 0; i < 3; i++) a_d[i] = a_q[i] << 1;
        end else begin
          sum_d   = '0;
          idx_d   = '0;
          state_d = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin
        prod_d  = mul_p;
        state_d = ST_SQ_ACC;
      end
      ST_SQ_ACC: begin
        sum_d = sum_n;
        if (idx_q == 2'd2) begin
          idx_d = '0;
          if (phase_q == PH_CHECK) begin
            if (sum_n > Q_ONE_SQ) begin
              phase_d = PH_CLAMP;
              state_d = ST_NORM;
            end else begin
              state_d = ST_MASS_GO;
            end
          end else begin
            state_d = ST_SQRT_GO;
          end
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_SQ_MUL;
        end
      end
      ST_SQRT_GO: begin
        itu_req.start = 1'b1;
        itu_req.mode  = ITU_SQRT;
        itu_req.steps = CNT_W'(SQRT_STEPS);
        state_d       = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (itu_rsp.done) begin
          len_d   = itu_rsp.root;
          idx_d   = '0;
          state_d = ST_LEN_MUL;
        end
      end
      ST_LEN_MUL: begin
        prod_d  = mul_p;
        state_d = ST_LEN_GO;
      end
      ST_LEN_GO: begin
        itu_req.start = 1'b1;
        state_d       = ST_LEN_WAIT;
      end
      ST_LEN_WAIT: begin
        if (itu_rsp.done) begin
          v_d[idx_q] = v_q[idx_q][VEC_W-1] ? -$signed(qv) : $signed(qv);
          if (idx_q == 2'd2) begin
            idx_d   = '0;
            state_d = (phase_q == PH_SEEK) ? ST_STEER : ST_MASS_GO;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = ST_LEN_MUL;
          end
        end
      end
      ST_STEER: begin
        for (int i = 0; i < 3; i++) begin
          v_d[i] = v_q[i] - VEC_W'(vel_q[i]);
        end
        phase_d = PH_CHECK;
        state_d = ST_MAG;
      end
      ST_MASS_GO: begin
        itu_req.start       = 1'b1;
        itu_req.steps       = CNT_W'(MASS_STEPS);
        itu_req.rem0        = '0;
        itu_req.dividend_lo = DIV_W'(mg[FRAC_BITS:0]) << (FRAC_BITS + DIV_W - MASS_STEPS);
        // A zero mass divides as one LSB.
        itu_req.divisor     = (mass_q == '0) ? 32'd1 : mass_q;
        state_d             = ST_MASS_WAIT;
      end
      ST_MASS_WAIT: begin
        if (itu_rsp.done) begin
          if (v_q[idx_q][VEC_W-1]) begin
            s_d = (q >= (DIV_W'(1) << 31)) ? 32'sh80000000 : -$signed(q[31:0]);
          end else begin
            s_d = (q > DIV_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(q[31:0]);
          end
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_d[idx_q] = sat32(35'(acc_q[idx_q]) + 35'(s_q));
        if (idx_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_MASS_GO;
        end
      end
      ST_DONE: begin
        if (ack_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_SEEK;
      idx_q   <= '0;
      mass_q  <= Q_ONE;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      mass_q  <= mass_d;
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    a_q    <= a_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
    len_q  <= len_d;
    s_q    <= s_d;
  end

  assign stat_o.idle    = (state_q == ST_IDLE);
  assign stat_o.done    = (state_q == ST_DONE);
  assign pos_o.pos_out_x = pos_q[0];
  assign pos_o.pos_out_y = pos_q[1];
  assign pos_o.pos_out_z = pos_q[2];

endmodule
